// ===== rtl/core/sqlvlc_pkg.sv =====
// ============================================================================
// SQL valid line counter package
// Shared widths, character codes, register indexes, types and helpers.
// ============================================================================
package sqlvlc_pkg;

  // Widths of the line, count, character and configuration fields.
  localparam int unsigned LineBits  = 20;
  localparam int unsigned CountBits = LineBits + 1;
  localparam int unsigned CharBits  = 16;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 20;

  // Character codes used by the scanner.
  localparam logic [CharBits-1:0] ChSpace  = 16'h0020;
  localparam logic [CharBits-1:0] ChTab    = 16'h0009;
  localparam logic [CharBits-1:0] ChCr     = 16'h000D;
  localparam logic [CharBits-1:0] ChLf     = 16'h000A;
  localparam logic [CharBits-1:0] ChNel    = 16'h0085;
  localparam logic [CharBits-1:0] ChLs     = 16'h2028;
  localparam logic [CharBits-1:0] ChPs     = 16'h2029;
  localparam logic [CharBits-1:0] ChDash   = 16'h002D;
  localparam logic [CharBits-1:0] ChSlash  = 16'h002F;
  localparam logic [CharBits-1:0] ChStar   = 16'h002A;
  localparam logic [CharBits-1:0] ChSQuote = 16'h0027;
  localparam logic [CharBits-1:0] ChDQuote = 16'h0022;
  localparam logic [CharBits-1:0] ChBslash = 16'h005C;

  // Configuration register indexes.
  typedef enum logic [CfgIdxBits-1:0] {
    RegStartLine  = 3'd0,
    RegStartCount = 3'd1,
    RegTargetLine = 3'd2,
    RegExtEol     = 3'd3
  } reg_idx_e;

  // Scan modes carried across lines.
  typedef enum logic [1:0] {
    ModeNormal  = 2'd0,
    ModeSQuote  = 2'd1,
    ModeDQuote  = 2'd2,
    ModeComment = 2'd3
  } mode_e;

  // Configuration register contents.
  typedef struct packed {
    logic [LineBits-1:0] start_line;
    logic [LineBits-1:0] start_count;
    logic [LineBits-1:0] target_line;
    logic                ext_eol;
  } cfg_t;

  // One input request.
  typedef struct packed {
    logic                cmd;
    logic [CharBits-1:0] ch;
    logic [CharBits-1:0] next_ch;
    logic                last_in_line;
  } item_t;

  // One result, with a flag that says whether the item produced it.
  typedef struct packed {
    logic                 valid;
    logic [LineBits-1:0]  line_number;
    logic                 line_valid;
    logic [CountBits-1:0] valid_count;
    logic                 target_reached;
  } result_t;

  // True for a line delimiter; the extended set is enabled by ext_eol.
  function automatic logic is_delim(input logic [CharBits-1:0] c, input logic ext);
    is_delim = (c == ChCr) || (c == ChLf) ||
               (ext && ((c == ChNel) || (c == ChLs) || (c == ChPs)));
  endfunction

endpackage

// ===== rtl/core/sqlvlc_item_if.sv =====
// ============================================================================
// SQL valid line counter input channel
// Character requests with a valid/ready handshake.
// ============================================================================
interface sqlvlc_item_if;
  import sqlvlc_pkg::*;

  logic                valid;
  logic                ready;
  logic                cmd;
  logic [CharBits-1:0] ch;
  logic [CharBits-1:0] next_ch;
  logic                last_in_line;

  modport source (output valid, cmd, ch, next_ch, last_in_line, input ready);
  modport sink   (input valid, cmd, ch, next_ch, last_in_line, output ready);
endinterface

// ===== rtl/core/sqlvlc_result_if.sv =====
// ============================================================================
// SQL valid line counter result channel
// One request per finished line with a valid/ready handshake.
// ============================================================================
interface sqlvlc_result_if;
  import sqlvlc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [LineBits-1:0]  line_number;
  logic                 line_valid;
  logic [CountBits-1:0] valid_count;
  logic                 target_reached;

  modport source (output valid, line_number, line_valid, valid_count, target_reached,
                  input ready);
  modport sink   (input valid, line_number, line_valid, valid_count, target_reached,
                  output ready);
endinterface

// ===== rtl/core/sqlvlc_cfg_if.sv =====
// ============================================================================
// SQL valid line counter configuration channel
// Register write requests carrying an index and write data.
// ============================================================================
interface sqlvlc_cfg_if;
  import sqlvlc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CfgIdxBits-1:0]  index;
  logic [CfgDataBits-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/sqlvlc_cfg_regs.sv =====
// ============================================================================
// SQL valid line counter configuration registers
// Decodes write requests into the four configuration registers.
// ============================================================================
module sqlvlc_cfg_regs import sqlvlc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   wr_en_i,
  input  logic [CfgIdxBits-1:0]  wr_idx_i,
  input  logic [CfgDataBits-1:0] wr_data_i,
  output cfg_t                   cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Write decode; unknown indexes are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_idx_i)
        RegStartLine:  cfg_d.start_line  = wr_data_i[LineBits-1:0];
        RegStartCount: cfg_d.start_count = wr_data_i[LineBits-1:0];
        RegTargetLine: cfg_d.target_line = wr_data_i[LineBits-1:0];
        RegExtEol:     cfg_d.ext_eol     = wr_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_line  <= '0;
      cfg_q.start_count <= '0;
      cfg_q.target_line <= LineBits'(1);
      cfg_q.ext_eol     <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/sqlvlc_scanner.sv =====
// ============================================================================
// SQL valid line counter scanner
// Holds the scan state and works out one character's effect and line result.
// ============================================================================
module sqlvlc_scanner import sqlvlc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  mode_e                mode_q, mode_d;
  logic [LineBits-1:0]  lc_q, lc_d;
  logic [CountBits-1:0] vc_q, vc_d;
  logic [CharBits-1:0]  prev_q, prev_d;
  logic                 lv_q, lv_d;
  logic                 skip_q, skip_d;
  logic                 rest_q, rest_d;
  logic                 lb_q, lb_d;
  logic                 fd_q, fd_d;
  logic                 con_q, con_d;
  logic                 done_q, done_d;

  // Next state and result for the presented character.
  always_comb begin
    logic                 is_blank;
    logic                 fin_valid;
    logic [CountBits-1:0] vc_inc;
    logic [LineBits-1:0]  teff;
    logic [CharBits-1:0]  c;
    logic [CharBits-1:0]  nx;
    logic                 last;

    c    = item_i.ch;
    nx   = item_i.next_ch;
    last = item_i.last_in_line;
    is_blank = (c == ChSpace) || (c == ChTab);

    mode_d = mode_q;
    lc_d   = lc_q;
    vc_d   = vc_q;
    prev_d = prev_q;
    lv_d   = lv_q;
    skip_d = skip_q;
    rest_d = rest_q;
    lb_d   = lb_q;
    fd_d   = fd_q;
    con_d  = con_q;
    done_d = done_q;
    fin_valid = 1'b0;
    vc_inc    = vc_q;
    teff      = cfg_i.target_line;
    res_o     = '0;

    if (item_i.cmd) begin
      // Restart from the configuration registers.
      mode_d = ModeNormal;
      lc_d   = cfg_i.start_line;
      vc_d   = {1'b0, cfg_i.start_count};
      con_d  = 1'b0;
      done_d = 1'b0;
      lv_d   = 1'b0;
      prev_d = '0;
      skip_d = 1'b0;
      rest_d = 1'b0;
      lb_d   = 1'b1;
      fd_d   = 1'b1;
    end else if (!done_q) begin
      if (skip_q) begin
        skip_d = 1'b0;
      end else if (!rest_q && !(lb_q && is_blank)) begin
        // First non-blank character of the line fixes the delimiter flag.
        if (lb_q) begin
          lb_d = 1'b0;
          fd_d = is_delim(c, cfg_i.ext_eol);
        end
        prev_d = c;
        unique case (mode_q)
          ModeSQuote, ModeDQuote: begin
            lv_d = 1'b1;
            if ((c == ((mode_q == ModeSQuote) ? ChSQuote : ChDQuote)) &&
                (prev_q != ChBslash)) begin
              mode_d = ModeNormal;
            end
          end
          ModeComment: begin
            if (!last && (c == ChStar) && (nx == ChSlash)) begin
              if (con_q) lv_d = 1'b1;
              skip_d = 1'b1;
              mode_d = ModeNormal;
            end
          end
          ModeNormal: begin
            priority if (is_blank || is_delim(c, cfg_i.ext_eol)) begin
              lv_d = lv_q;
            end else if (!last && (c == ChDash) && (nx == ChDash)) begin
              lv_d   = 1'b1;
              rest_d = 1'b1;
            end else if (!last && (c == ChSlash) && (nx == ChStar)) begin
              skip_d = 1'b1;
              mode_d = ModeComment;
              con_d  = (lc_q != LineBits'(1));
            end else if (c == ChSQuote) begin
              mode_d = ModeSQuote;
            end else if (c == ChDQuote) begin
              mode_d = ModeDQuote;
            end else begin
              lv_d = 1'b1;
            end
          end
          default: ;
        endcase
      end

      // End of line: judge the line, count it and emit the result.
      if (last) begin
        fin_valid = lv_d;
        if (mode_d == ModeComment) begin
          if (con_d) fin_valid = 1'b1;
          if (fd_d)  fin_valid = 1'b0;
        end
        if (teff == '0) teff = LineBits'(1);
        if (fin_valid && (vc_q != {CountBits{1'b1}})) vc_inc = vc_q + CountBits'(1);
        res_o.valid          = 1'b1;
        res_o.line_number    = lc_q;
        res_o.line_valid     = fin_valid;
        res_o.valid_count    = vc_inc;
        res_o.target_reached = fin_valid && (vc_inc > {1'b0, teff});
        done_d = res_o.target_reached;
        vc_d   = vc_inc;
        lc_d   = lc_q + LineBits'(1);
        lv_d   = 1'b0;
        prev_d = '0;
        skip_d = 1'b0;
        rest_d = 1'b0;
        lb_d   = 1'b1;
        fd_d   = 1'b1;
      end
    end
  end

  // Scan state, updated once per accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeNormal;
      lc_q   <= '0;
      vc_q   <= '0;
      prev_q <= '0;
      lv_q   <= 1'b0;
      skip_q <= 1'b0;
      rest_q <= 1'b0;
      lb_q   <= 1'b1;
      fd_q   <= 1'b1;
      con_q  <= 1'b0;
      done_q <= 1'b0;
    end else if (en_i) begin
      mode_q <= mode_d;
      lc_q   <= lc_d;
      vc_q   <= vc_d;
      prev_q <= prev_d;
      lv_q   <= lv_d;
      skip_q <= skip_d;
      rest_q <= rest_d;
      lb_q   <= lb_d;
      fd_q   <= fd_d;
      con_q  <= con_d;
      done_q <= done_d;
    end
  end

  // A restart always returns to normal mode with counting enabled.
  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && item_i.cmd |=> mode_q == ModeNormal && !done_q && !con_q)
    else $error("restart did not clear the scan state");

  // A line that reaches the target stops counting.
  a_reach_sets_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && res_o.valid && res_o.target_reached |=> done_q)
    else $error("target reached without setting the done flag");

  // Once done, characters leave the counters alone.
  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && done_q && !item_i.cmd |=> $stable(lc_q) && $stable(vc_q))
    else $error("counters moved after the target was reached");

  // The valid count never falls between restarts.
  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && !item_i.cmd |=> vc_q >= $past(vc_q))
    else $error("valid line count decreased");

  // No result is produced while done or on a restart.
  a_no_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q || item_i.cmd) |-> !res_o.valid)
    else $error("result produced while counting is stopped");

endmodule

// ===== rtl/core/sql_valid_line_counter_unit.sv =====
// ============================================================================
// SQL valid line counter
// Scans SQL text one code unit per request and counts lines that hold code.
// ============================================================================
// Channel   Dir  Handshake         Payload
// item_i    in   valid / ready     cmd, ch, next_ch, last_in_line
// result_o  out  valid / ready     line_number, line_valid, valid_count, target_reached
// cfg_i     in   valid / ready     index, data (ready always high)
//
// Each request passes an input register and then the scanner logic into the
// result register, which presents the result; one request is taken a cycle
// while no stalled result blocks it.
// The scan state is registered and fed back, which sets the rate of one per cycle.
// Reset loads the configuration defaults and a restarted scan state.
// A stalled result blocks only requests that would produce a further result.
// ============================================================================
module sql_valid_line_counter_unit import sqlvlc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  sqlvlc_item_if.sink     item_i,
  sqlvlc_result_if.source result_o,
  sqlvlc_cfg_if.sink      cfg_i
);

  cfg_t    cfg;
  result_t res;
  item_t   item_q;
  logic    in_valid_q;
  logic    adv;
  logic    out_valid_q, out_valid_d;
  result_t out_q;

  // Configuration writes are always taken.
  assign cfg_i.ready = 1'b1;

  sqlvlc_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_i.valid),
    .wr_idx_i  (cfg_i.index),
    .wr_data_i (cfg_i.data),
    .cfg_o     (cfg)
  );

  // Advance when the held request has no result or the result register is free.
  assign adv = in_valid_q && (!out_valid_q || result_o.ready || !res.valid);
  assign item_i.ready = !in_valid_q || adv;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      in_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      item_q.cmd          <= item_i.cmd;
      item_q.ch           <= item_i.ch;
      item_q.next_ch      <= item_i.next_ch;
      item_q.last_in_line <= item_i.last_in_line;
    end
  end

  sqlvlc_scanner u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (result_o.ready) out_valid_d = 1'b0;
    if (adv && res.valid) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res.valid) begin
      out_q <= res;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.line_number    = out_q.line_number;
  assign result_o.line_valid     = out_q.line_valid;
  assign result_o.valid_count    = out_q.valid_count;
  assign result_o.target_reached = out_q.target_reached;

endmodule
